// ===== hw/rtl/mipid_pkg.sv =====
// Shared types and constants for the multi-instance PID controller.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mipid_pkg;
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusDuplicate = 2'd1;
  localparam logic [1:0] StatusFull      = 2'd2;
  localparam logic [1:0] StatusUnknown   = 2'd3;
  localparam logic       CmdCreate       = 1'b0;
  localparam logic       CmdStep         = 1'b1;
  localparam logic [31:0] StepIntervalReset = 32'h0001_0000;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -66'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/mipid_div.sv =====
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module mipid_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [48:0] num_i,
  input  wire logic        [31:0] den_i,
  output logic                    done_o,
  output logic signed [49:0]      quo_o
);
  logic [48:0] rem_q, rem_d;
  logic [48:0] quo_q, quo_d;
  logic [48:0] num_abs_q;
  logic [31:0] den_q;
  logic        neg_q, busy_q;
  logic [5:0]  cnt_q;
  logic [49:0] trial;

  // shift-subtract step
  always_comb begin
    trial = {rem_q, num_abs_q[6'd48 - cnt_q]};
    rem_d = trial[48:0];
    quo_d = {quo_q[47:0], 1'b0};
    if (trial >= {18'd0, den_q}) begin
      rem_d = 49'(trial - {18'd0, den_q});
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q    <= 1'b1;
        cnt_q     <= '0;
        rem_q     <= '0;
        quo_q     <= '0;
        den_q     <= den_i;
        neg_q     <= num_i[48];
        num_abs_q <= num_i[48] ? 49'(-num_i) : num_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd48) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign quo_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule
`default_nettype wire

// ===== hw/rtl/multi_instance_pid_controller.sv =====
// Multi-instance PID controller, Q16.16, top level.
// Depends on mipid_pkg and mipid_div.
// A create or an unknown step searches the table entry by entry; a known step then also runs
// the serial divider, which is skipped when step_interval is 0. One request in the datapath
// at a time; the next can be accepted in the cycle after its result is registered, while
// that result waits in the output register.
// Reset clears the instance count and sets step_interval to 1.0; tables hold junk.
`timescale 1ns / 1ps
`default_nettype none
module multi_instance_pid_controller #(
  parameter int INSTANCES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic        [31:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               cmd_i,
  input  wire logic        [15:0] tag_i,
  input  wire logic signed [31:0] gain_p_i,
  input  wire logic signed [31:0] gain_i_i,
  input  wire logic signed [31:0] gain_d_i,
  input  wire logic signed [31:0] measured_i,
  input  wire logic signed [31:0] target_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [1:0]  status_o,
  output logic signed      [31:0] drive_o
);
  localparam int IW = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
  localparam int CW = $clog2(INSTANCES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_CMP, S_DECIDE, S_CALC0, S_DIV, S_MUL, S_SUM, S_OUT
  } state_e;

  // memories: tag and gains, error state
  logic [15:0]        tag_mem [INSTANCES];
  logic signed [31:0] kp_mem  [INSTANCES];
  logic signed [31:0] ki_mem  [INSTANCES];
  logic signed [31:0] kd_mem  [INSTANCES];
  logic signed [31:0] le_mem  [INSTANCES];
  logic signed [31:0] es_mem  [INSTANCES];

  state_e             state_q;
  logic [31:0]        dt_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      idx_q;
  logic [IW-1:0]      slot_q;
  logic               req_cmd_q;
  logic [15:0]        req_tag_q;
  logic signed [31:0] req_kp_q, req_ki_q, req_kd_q, req_meas_q, req_tgt_q;
  logic [15:0]        rd_tag_q;
  logic signed [31:0] kp_q, ki_q, kd_q, le_q, es_q;
  logic signed [31:0] e_q, integ_q, deriv_q;
  logic signed [63:0] pp_q, pi_q, pd_q;
  logic [1:0]         status_q;
  logic signed [31:0] drive_q;
  logic               div_start;
  logic               div_done;
  logic signed [49:0] div_quo;
  logic signed [48:0] div_num;
  logic signed [65:0] e_wide, integ_wide, sum_wide;
  logic [IW-1:0]      rd_addr;

  assign in_ready_o  = (state_q == S_IDLE);
  assign rd_addr     = (state_q == S_SEARCH) ? idx_q[IW-1:0] : slot_q;
  assign div_start   = (state_q == S_CALC0) && (dt_q != 32'd0);
  assign div_num     = 49'($signed(e_q) - $signed(le_q)) <<< 16;

  // error and integral from read state, sum of the scaled products
  always_comb begin
    e_wide     = 66'($signed(req_tgt_q)) - 66'($signed(req_meas_q));
    integ_wide = 66'($signed(es_q)) +
                 66'($signed(64'(e_q) * $signed({32'd0, dt_q})) >>> 16);
    sum_wide   = 66'(pp_q >>> 16) + 66'(pi_q >>> 16) + 66'(pd_q >>> 16);
  end

  mipid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // synchronous reads
  always_ff @(posedge clk_i) begin
    rd_tag_q <= tag_mem[rd_addr];
    kp_q     <= kp_mem[rd_addr];
    ki_q     <= ki_mem[rd_addr];
    kd_q     <= kd_mem[rd_addr];
    le_q     <= le_mem[rd_addr];
    es_q     <= es_mem[rd_addr];
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (state_q == S_DECIDE && req_cmd_q == mipid_pkg::CmdCreate &&
        idx_q == count_q && count_q != CW'(INSTANCES)) begin
      tag_mem[count_q[IW-1:0]] <= req_tag_q;
      kp_mem[count_q[IW-1:0]]  <= req_kp_q;
      ki_mem[count_q[IW-1:0]]  <= req_ki_q;
      kd_mem[count_q[IW-1:0]]  <= req_kd_q;
      le_mem[count_q[IW-1:0]]  <= '0;
      es_mem[count_q[IW-1:0]]  <= '0;
    end
    if (state_q == S_MUL) begin
      le_mem[slot_q] <= e_q;
      es_mem[slot_q] <= integ_q;
    end
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dt_q        <= mipid_pkg::StepIntervalReset;
      count_q     <= '0;
      out_valid_o <= 1'b0;
      status_o    <= '0;
      drive_o     <= '0;
    end else begin
      if (cfg_we_i) dt_q <= cfg_data_i;
      if (out_valid_o && out_ready_i && state_q != S_OUT) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            req_cmd_q  <= cmd_i;
            req_tag_q  <= tag_i;
            req_kp_q   <= gain_p_i;
            req_ki_q   <= gain_i_i;
            req_kd_q   <= gain_d_i;
            req_meas_q <= measured_i;
            req_tgt_q  <= target_i;
            idx_q      <= '0;
            state_q    <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (idx_q == count_q) state_q <= S_DECIDE;
          else begin
            slot_q  <= idx_q[IW-1:0];
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_tag_q == req_tag_q) state_q <= S_DECIDE;
          else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_SEARCH;
          end
        end
        S_DECIDE: begin
          drive_q <= '0;
          if (req_cmd_q == mipid_pkg::CmdCreate) begin
            if (idx_q != count_q) status_q <= mipid_pkg::StatusDuplicate;
            else if (count_q == CW'(INSTANCES)) status_q <= mipid_pkg::StatusFull;
            else begin
              status_q <= mipid_pkg::StatusOk;
              count_q  <= count_q + CW'(1);
            end
            state_q <= S_OUT;
          end else if (idx_q == count_q) begin
            status_q <= mipid_pkg::StatusUnknown;
            state_q  <= S_OUT;
          end else begin
            status_q <= mipid_pkg::StatusOk;
            e_q      <= mipid_pkg::sat32(e_wide);
            state_q  <= S_CALC0;
          end
        end
        S_CALC0: begin
          integ_q <= mipid_pkg::sat32(integ_wide);
          deriv_q <= '0;
          state_q <= (dt_q != 32'd0) ? S_DIV : S_MUL;
        end
        S_DIV: begin
          if (div_done) begin
            deriv_q <= mipid_pkg::sat32(66'(div_quo));
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          pp_q    <= kp_q * e_q;
          pi_q    <= ki_q * integ_q;
          pd_q    <= kd_q * deriv_q;
          state_q <= S_SUM;
        end
        S_SUM: begin
          drive_q <= mipid_pkg::sat32(sum_wide);
          state_q <= S_OUT;
        end
        // load the output register once the previous result has left
        S_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            status_o    <= status_q;
            drive_o     <= drive_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== dv/multi_instance_pid_controller_checker.sv =====
// Scoreboard for the multi-instance PID controller: predicts each result from
// accepted requests and the step interval, compares status and drive. Uses mipid_pkg.
`timescale 1ns / 1ps
module multi_instance_pid_controller_checker #(
  parameter int INSTANCES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [31:0] cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               cmd_i,
  input  logic        [15:0] tag_i,
  input  logic signed [31:0] gain_p_i,
  input  logic signed [31:0] gain_i_i,
  input  logic signed [31:0] gain_d_i,
  input  logic signed [31:0] measured_i,
  input  logic signed [31:0] target_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic        [1:0]  status_i,
  input  logic signed [31:0] drive_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] drive;
  } pid_result_t;

  pid_result_t pending_results[$];

  // shadow of the controller table
  logic [31:0]        dt_shadow;
  int                 count_shadow;
  logic [15:0]        tag_shadow [INSTANCES];
  logic signed [31:0] kp_shadow  [INSTANCES];
  logic signed [31:0] ki_shadow  [INSTANCES];
  logic signed [31:0] kd_shadow  [INSTANCES];
  logic signed [31:0] last_err_shadow [INSTANCES];
  logic signed [31:0] err_sum_shadow  [INSTANCES];

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    logic signed [31:0] r;
    if (v > 128'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -128'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // compute one result and update the shadow table
  function automatic pid_result_t predict_pid(input logic cmd, input logic [15:0] tag,
      input logic signed [31:0] kp, input logic signed [31:0] ki,
      input logic signed [31:0] kd, input logic signed [31:0] meas,
      input logic signed [31:0] tgt);
    pid_result_t r;
    int slot;
    logic signed [127:0] e, integ, deriv, sum, dt;
    slot = -1;
    r.status = mipid_pkg::StatusOk;
    r.drive = '0;
    for (int i = 0; i < count_shadow; i++)
      if (slot < 0 && tag_shadow[i] == tag) slot = i;
    if (cmd == mipid_pkg::CmdCreate) begin
      if (slot >= 0) r.status = mipid_pkg::StatusDuplicate;
      else if (count_shadow >= INSTANCES) r.status = mipid_pkg::StatusFull;
      else begin
        tag_shadow[count_shadow] = tag;
        kp_shadow[count_shadow] = kp;
        ki_shadow[count_shadow] = ki;
        kd_shadow[count_shadow] = kd;
        last_err_shadow[count_shadow] = '0;
        err_sum_shadow[count_shadow] = '0;
        count_shadow++;
      end
    end else if (slot < 0) begin
      r.status = mipid_pkg::StatusUnknown;
    end else begin
      dt = $signed({96'd0, dt_shadow});
      e = clamp32(128'(tgt) - 128'(meas));
      // arithmetic shift is floor for signed values
      integ = clamp32(128'(err_sum_shadow[slot]) + ((e * dt) >>> 16));
      deriv = 0;
      if (dt != 0) deriv = clamp32(((e - 128'(last_err_shadow[slot])) * 65536) / dt);
      sum = ((128'(kp_shadow[slot]) * e) >>> 16) + ((128'(ki_shadow[slot]) * integ) >>> 16)
          + ((128'(kd_shadow[slot]) * deriv) >>> 16);
      r.drive = clamp32(sum);
      last_err_shadow[slot] = e[31:0];
      err_sum_shadow[slot] = integ[31:0];
    end
    return r;
  endfunction

  assign pending_o = pending_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pid_result_t want;
    if (!rst_ni) begin
      dt_shadow = mipid_pkg::StepIntervalReset;
      count_shadow = 0;
      fail_count_o <= 0;
      pending_results.delete();
    end else begin
      if (cfg_we_i) dt_shadow = cfg_data_i;
      if (in_valid_i && in_ready_i)
        pending_results.push_back(predict_pid(cmd_i, tag_i, gain_p_i, gain_i_i,
            gain_d_i, measured_i, target_i));
      // compare a completed result against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status %0d drive %0d", $time, status_i, drive_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pending_results.pop_front();
          if (want.status !== status_i || want.drive !== drive_i) begin
            $display("%0t: mismatch expected status %0d drive %0d, got status %0d drive %0d",
                $time, want.status, want.drive, status_i, drive_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== dv/multi_instance_pid_controller_test.sv =====
// Testbench top for the multi-instance PID controller: drives directed and
// random requests and config writes. Uses mipid_pkg and the checker module.
`timescale 1ns / 1ps
module multi_instance_pid_controller_test;
  localparam int INSTANCES = 16;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = 1'b0;
  logic [15:0] tag_i = '0;
  logic signed [31:0] gain_p_i = '0, gain_i_i = '0, gain_d_i = '0;
  logic signed [31:0] measured_i = '0, target_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic signed [31:0] drive_o;
  int fail_count, pending_count;
  int idle_pct = 14;
  int quiet_cycles = 0;
  logic [15:0] live_tags [$];

  always #2 clk_i = ~clk_i;

  multi_instance_pid_controller #(.INSTANCES(INSTANCES)) u_top (.*);

  multi_instance_pid_controller_checker #(.INSTANCES(INSTANCES)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_ready_i(in_ready_o),
    .cmd_i, .tag_i, .gain_p_i, .gain_i_i, .gain_d_i, .measured_i, .target_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o), .drive_i(drive_o),
    .fail_count_o(fail_count), .pending_o(pending_count));

  // result side back-pressure
  always @(posedge clk_i)
    out_ready_i <= ($urandom_range(99) >= idle_pct);

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** multi_instance_pid_controller: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] rand_q(input int mode);
    case (mode)
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // idle gaps drop valid; valid then stays high until the request is taken
  task automatic send_request(input logic cmd, input logic [15:0] tag,
      input logic [31:0] kp, input logic [31:0] ki, input logic [31:0] kd,
      input logic [31:0] meas, input logic [31:0] tgt);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    tag_i <= tag;
    gain_p_i <= kp;
    gain_i_i <= ki;
    gain_d_i <= kd;
    measured_i <= meas;
    target_i <= tgt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (INSTANCES + 70) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [31:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly steps on live instances, some creates and unknown tags
  task automatic random_request();
    int pick;
    logic [15:0] tag;
    pick = $urandom_range(99);
    if (pick < 8 || live_tags.size() == 0) begin
      tag = (pick < 3 && live_tags.size() != 0) ?
          live_tags[$urandom_range(live_tags.size() - 1)] : 16'($urandom);
      if (live_tags.size() < INSTANCES && !(tag inside {live_tags})) live_tags.push_back(tag);
      send_request(mipid_pkg::CmdCreate, tag, rand_q($urandom_range(3)),
          rand_q($urandom_range(3)), rand_q($urandom_range(3)), $urandom, $urandom);
    end else begin
      tag = (pick < 14) ? 16'($urandom) : live_tags[$urandom_range(live_tags.size() - 1)];
      send_request(mipid_pkg::CmdStep, tag, $urandom, $urandom, $urandom,
          rand_q($urandom_range(4)), rand_q($urandom_range(4)));
    end
  endtask

  initial begin
    logic [31:0] intervals [6];
    intervals = '{32'h0000_0001, 32'hffff_ffff, 32'h0000_0000, 32'h0000_8000,
        32'h0003_0000, 32'h0001_0000};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unknown step, creates up to a full table, duplicates, extremes
    send_request(mipid_pkg::CmdStep, 16'h0000, '0, '0, '0, '0, '0);
    send_request(mipid_pkg::CmdCreate, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff,
        32'h7fff_ffff, '0, '0);
    send_request(mipid_pkg::CmdCreate, 16'h0000, 32'h8000_0000, 32'h8000_0000,
        32'h8000_0000, '0, '0);
    send_request(mipid_pkg::CmdCreate, 16'hffff, '0, '0, '0, '0, '0);
    live_tags = '{16'hffff, 16'h0000};
    send_request(mipid_pkg::CmdStep, 16'hffff, '0, '0, '0, 32'h8000_0000, 32'h7fff_ffff);
    send_request(mipid_pkg::CmdStep, 16'hffff, '0, '0, '0, 32'h7fff_ffff, 32'h8000_0000);
    send_request(mipid_pkg::CmdStep, 16'h0000, '0, '0, '0, 32'h8000_0000, 32'h7fff_ffff);
    send_request(mipid_pkg::CmdStep, 16'h0000, '0, '0, '0, 32'h0001_0000, 32'h0000_0000);
    for (int i = 2; i < INSTANCES; i++) begin
      send_request(mipid_pkg::CmdCreate, 16'(i * 4099), 32'h0001_0000, 32'h0000_8000,
          32'hffff_0000, '0, '0);
      live_tags.push_back(16'(i * 4099));
    end
    send_request(mipid_pkg::CmdCreate, 16'h1234, '0, '0, '0, '0, '0);
    send_request(mipid_pkg::CmdStep, 16'h1234, '0, '0, '0, '0, '0);
    write_interval(32'h0000_0000);
    send_request(mipid_pkg::CmdStep, 16'h0000, '0, '0, '0, 32'h0000_0000, 32'h7fff_ffff);

    // random phases across step intervals; a reset-free run keeps the table full
    for (int phase = 0; phase < 6; phase++) begin
      write_interval(phase == 5 ? 32'($urandom) : intervals[phase]);
      idle_pct = (phase == 3) ? 0 : 14;
      for (int n = 0; n < 290; n++) random_request();
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("** multi_instance_pid_controller: PASSED **");
    end else begin
      $display("** multi_instance_pid_controller: FAILED **");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/mipid_pkg.sv
hw/rtl/mipid_div.sv
hw/rtl/multi_instance_pid_controller.sv
dv/multi_instance_pid_controller_checker.sv
dv/multi_instance_pid_controller_test.sv
